/* hdl/pfc_pkg.sv */
// Shared types, constants, microcode program and arithmetic helpers of the PLL frequency codec.
`timescale 1ns / 1ps

package pfc_pkg;

  // Field widths of the items.
  localparam int FreqW = 11;
  localparam int WordW = 32;
  localparam int FoutW = 12;

  // Crystal and divider constants.
  localparam int XtalMhz    = 12;
  localparam int DnSpan     = 256;
  localparam int XLimit     = DnSpan * XtalMhz;
  localparam int MaxDm      = 8;
  localparam int RangeBase  = 800;
  localparam int RangeStep  = 300;
  localparam int SysDivBit  = 32;
  localparam int MinClock   = 800;
  localparam int MaxClock   = 1999;
  localparam int RecipShift = 16;

  // The range term below the base frequency wraps around 2^32 before the divide.
  localparam longint unsigned WordSpan = 64'd1 << 32;
  localparam int WrapByte = int'((WordSpan / RangeStep) % 256);
  localparam int WrapRem  = int'(WordSpan % RangeStep);

  // Datapath operations driven by the microcode.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT,
    OP_DIV_X,
    OP_REM,
    OP_DIV_F,
    OP_PACK,
    OP_LD_DEC,
    OP_SET_F,
    OP_DONE
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DECODE,
    C_BAD,
    C_X_OVER,
    C_LOOP_ON
  } cond_e;

  localparam int PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  // Program addresses.
  localparam pc_t PcStart  = 4'd0;
  localparam pc_t PcChk    = 4'd1;
  localparam pc_t PcPack   = 4'd2;
  localparam pc_t PcLoop   = 4'd3;
  localparam pc_t PcRem    = 4'd4;
  localparam pc_t PcDivF   = 4'd5;
  localparam pc_t PcWord   = 4'd6;
  localparam pc_t PcDec    = 4'd7;
  localparam pc_t PcDecDiv = 4'd8;
  localparam pc_t PcSetF   = 4'd9;
  localparam pc_t PcDone   = 4'd10;
  localparam pc_t PcLast   = PcDone;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic decode;
    logic bad;
    logic x_over;
    logic loop_on;
  } status_t;

  typedef struct packed {
    logic [WordW-1:0] pll_config;
    logic [FoutW-1:0] freq_out;
    logic             range_error;
  } result_t;

  // Control store: one control word per step.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    w = '{op: OP_DONE, cond: C_NEVER, target: PcDone};
    unique case (pc)
      PcStart:  w = '{op: OP_NOP,    cond: C_DECODE,  target: PcDec};
      PcChk:    w = '{op: OP_NOP,    cond: C_BAD,     target: PcDone};
      PcPack:   w = '{op: OP_INIT,   cond: C_NEVER,   target: PcPack};
      PcLoop:   w = '{op: OP_DIV_X,  cond: C_X_OVER,  target: PcDivF};
      PcRem:    w = '{op: OP_REM,    cond: C_LOOP_ON, target: PcLoop};
      PcDivF:   w = '{op: OP_DIV_F,  cond: C_NEVER,   target: PcDivF};
      PcWord:   w = '{op: OP_PACK,   cond: C_ALWAYS,  target: PcDone};
      PcDec:    w = '{op: OP_LD_DEC, cond: C_NEVER,   target: PcDec};
      PcDecDiv: w = '{op: OP_DIV_F,  cond: C_NEVER,   target: PcDecDiv};
      PcSetF:   w = '{op: OP_SET_F,  cond: C_ALWAYS,  target: PcPack};
      PcDone:   w = '{op: OP_DONE,   cond: C_NEVER,   target: PcDone};
      default:  w = '{op: OP_DONE,   cond: C_NEVER,   target: PcDone};
    endcase
    return w;
  endfunction

  // ceil(2^16 / d); exact floor division for 12-bit dividends and d up to 16.
  function automatic logic [16:0] recip(input logic [4:0] d);
    logic [16:0] m;
    unique case (d)
      5'd1:    m = 17'd65536;
      5'd2:    m = 17'd32768;
      5'd3:    m = 17'd21846;
      5'd4:    m = 17'd16384;
      5'd5:    m = 17'd13108;
      5'd6:    m = 17'd10923;
      5'd7:    m = 17'd9363;
      5'd8:    m = 17'd8192;
      5'd9:    m = 17'd7282;
      5'd10:   m = 17'd6554;
      5'd11:   m = 17'd5958;
      5'd12:   m = 17'd5462;
      5'd13:   m = 17'd5042;
      5'd14:   m = 17'd4682;
      5'd15:   m = 17'd4370;
      5'd16:   m = 17'd4096;
      default: m = 17'd0;
    endcase
    return m;
  endfunction

  // Range code: (f - 800) / 300 taken modulo 2^32, low byte.
  function automatic logic [7:0] range_code(input logic [FoutW-1:0] f);
    logic [2:0]       k_up;
    logic [1:0]       k_dn;
    logic [FoutW-1:0] gap;
    logic [7:0]       code;
    k_up = '0;
    k_dn = '0;
    gap  = FoutW'(RangeBase) - f;
    for (int k = 1; k <= 7; k++) begin
      if (f >= FoutW'(RangeBase + k * RangeStep)) begin
        k_up = k_up + 3'd1;
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (gap > FoutW'(WrapRem + j * RangeStep)) begin
        k_dn = k_dn + 2'd1;
      end
    end
    if (f >= FoutW'(RangeBase)) begin
      code = {5'd0, k_up};
    end else begin
      code = 8'(WrapByte) - {6'd0, k_dn};
    end
    return code;
  endfunction

endpackage

/* hdl/pfc_in_if.sv */
// Input channel of the PLL frequency codec: handshake and request fields.
`timescale 1ns / 1ps

interface pfc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [10:0] freq_mhz;
  logic [31:0] pll_word;

  modport source (output valid, action, freq_mhz, pll_word, input ready);
  modport sink (input valid, action, freq_mhz, pll_word, output ready);
endinterface

/* hdl/pfc_out_if.sv */
// Output channel of the PLL frequency codec: handshake and result fields.
`timescale 1ns / 1ps

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pll_config;
  logic [11:0] freq_out;
  logic        range_error;

  modport source (output valid, pll_config, freq_out, range_error, input ready);
  modport sink (input valid, pll_config, freq_out, range_error, output ready);
endinterface

/* hdl/pfc_recip_div.sv */
// Small-divisor divider: multiply by a tabled reciprocal, registered quotient.
`timescale 1ns / 1ps

module pfc_recip_div import pfc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [FoutW-1:0] num_i,
  input  logic [4:0]       den_i,
  output logic [FoutW-1:0] quo_o
);

  localparam int ProdW = FoutW + 17;

  logic [ProdW-1:0] prod;
  logic [FoutW-1:0] quo_q;

  assign prod  = {17'd0, num_i} * {{FoutW{1'b0}}, recip(den_i)};
  assign quo_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= prod[RecipShift +: FoutW];
    end
  end

endmodule

/* hdl/pfc_datapath.sv */
// Datapath of the PLL frequency codec: working registers, divider and word packing.
`timescale 1ns / 1ps

module pfc_datapath import pfc_pkg::*; (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             action_i,
  input  logic [FreqW-1:0] freq_mhz_i,
  input  logic [WordW-1:0] pll_word_i,
  input  op_e              op_i,
  output status_t          status_o,
  output result_t          result_o
);

  logic             act_q;
  logic             bad_q;
  logic [WordW-1:0] word_q;
  logic [FoutW-1:0] f_q;
  logic [12:0]      x_q;
  logic [3:0]       t_q;
  logic [3:0]       best_q;
  logic [4:0]       dm_q;
  logic [8:0]       dn_q;
  logic [WordW-1:0] pack_q;
  logic [FoutW-1:0] f2_q;

  logic             div_en;
  logic [FoutW-1:0] div_num;
  logic [4:0]       div_den;
  logic [FoutW-1:0] quo;
  logic [FoutW-1:0] dn_x12;
  logic [FoutW-1:0] quo_x12;
  logic [FoutW-1:0] rem_full;
  logic [3:0]       rem;
  logic             take;

  // dn*12 and q*12 as shift-adds.
  assign dn_x12  = {dn_q, 3'b000} + {1'b0, dn_q, 2'b00};
  assign quo_x12 = {quo[8:0], 3'b000} + {quo[9:0], 2'b00};

  assign div_en  = (op_i == OP_DIV_X) || (op_i == OP_DIV_F);
  assign div_num = (op_i == OP_DIV_F) ? dn_x12 : x_q[FoutW-1:0];
  assign div_den = (op_i == OP_DIV_F) ? dm_q : 5'(XtalMhz);

  pfc_recip_div u_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .num_i (div_num),
    .den_i (div_den),
    .quo_o (quo)
  );

  // Remainder of the current trial product by the crystal frequency.
  assign rem_full = x_q[FoutW-1:0] - quo_x12;
  assign rem      = rem_full[3:0];
  assign take     = (rem <= best_q);

  assign status_o.decode  = act_q;
  assign status_o.bad     = bad_q;
  assign status_o.x_over  = (x_q > 13'(XLimit));
  assign status_o.loop_on = (rem != 4'd0) && (t_q < 4'(MaxDm));

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      act_q  <= action_i;
      bad_q  <= (freq_mhz_i < FreqW'(MinClock)) || (freq_mhz_i > FreqW'(MaxClock));
      word_q <= pll_word_i;
      f_q    <= {1'b0, freq_mhz_i};
    end
    unique case (op_i)
      OP_INIT: begin
        x_q    <= {1'b0, f_q};
        t_q    <= 4'd1;
        best_q <= 4'(XtalMhz);
        dm_q   <= 5'd1;
      end
      OP_REM: begin
        if (take) begin
          best_q <= rem;
          dm_q   <= {1'b0, t_q};
          dn_q   <= quo[8:0];
        end
        x_q <= x_q + {1'b0, f_q};
        t_q <= t_q + 4'd1;
      end
      OP_LD_DEC: begin
        dn_q <= {1'b0, word_q[7:0]} + 9'd1;
        dm_q <= {1'b0, word_q[11:8]} + 5'd1;
      end
      OP_SET_F: begin
        f_q <= quo;
      end
      OP_PACK: begin
        pack_q <= {8'd0, range_code(quo) | 8'(SysDivBit), 8'(dm_q - 5'd1), 8'(dn_q - 9'd1)};
        f2_q   <= quo;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result_o = '0;
    if (!act_q) begin
      if (bad_q) begin
        result_o.range_error = 1'b1;
      end else begin
        result_o.pll_config = pack_q;
        result_o.freq_out   = f2_q;
      end
    end else if (pack_q == word_q) begin
      result_o.freq_out = f_q;
    end
  end

endmodule

/* hdl/pfc_sequencer.sv */
// Microcode sequencer of the PLL frequency codec: step counter, control store and jumps.
`timescale 1ns / 1ps

module pfc_sequencer import pfc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    out_free_i,
  input  status_t status_i,
  output op_e     op_o,
  output logic    busy_o,
  output logic    done_o
);

  pc_t    pc_q, pc_d;
  logic   busy_q, busy_d;
  uword_t uw;
  logic   jump;

  assign uw     = ucode(pc_q);
  assign busy_o = busy_q;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:   jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_DECODE:  jump = status_i.decode;
      C_BAD:     jump = status_i.bad;
      C_X_OVER:  jump = status_i.x_over;
      C_LOOP_ON: jump = status_i.loop_on;
      default:   jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    op_o   = OP_NOP;
    done_o = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        pc_d   = PcStart;
        busy_d = 1'b1;
      end
    end else if (uw.op == OP_DONE) begin
      // Hold here until the output register can take the result.
      if (out_free_i) begin
        done_o = 1'b1;
        busy_d = 1'b0;
      end
    end else begin
      op_o = uw.op;
      pc_d = jump ? uw.target : pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= PcStart;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("item started while the sequencer is busy");

  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= PcLast))
    else $error("step counter left the program");

  a_only_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (uw.op != OP_DONE)) |=> busy_q)
    else $error("sequencer went idle outside the final step");

endmodule

/* hdl/pll_frequency_codec.sv */
// Top level of the PLL frequency codec: handshakes, sequencer, datapath and output register.
`timescale 1ns / 1ps

// Converts between a clock frequency in MHz and a 32-bit PLL configuration word for a
// 12 MHz crystal. With action 0 the block encodes freq_mhz (valid 800 to 1999): it tries
// the feedback divider dm from 1 to 8, keeps the one with the smallest remainder of
// freq*dm mod 12 (ties go to the larger dm), and returns the packed word together with
// the frequency it actually achieves; a request outside 800 to 1999 returns zeros and
// range_error. With action 1 the block decodes pll_word and returns the frequency only
// if re-encoding it gives back the same word, and 0 otherwise. Items are handled one at
// a time by a small microprogram. Each divider trial is a divide step followed by a
// remainder-and-compare step on the shared reciprocal multiplier. The search stops
// once freq*dm passes 3072, and an in-range encode never needs more than three
// trials; an out-of-range encode skips the search. The input is ready again in the
// cycle after the result is loaded. A new item is taken as soon as the previous
// result sits in the output register, even if the sink has not taken it yet; while
// that register is full and the sink stalls, the sequencer waits at its final step.
module pll_frequency_codec import pfc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  pfc_in_if.sink    in_i,
  pfc_out_if.source out_o
);

  logic    accept;
  logic    busy;
  logic    done;
  logic    out_free;
  op_e     op;
  status_t status;
  result_t result;

  logic    out_valid_q, out_valid_d;
  result_t res_q;

  assign in_i.ready = !busy;
  assign accept     = in_i.valid && in_i.ready;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_o.ready;

  pfc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_free_i (out_free),
    .status_i   (status),
    .op_o       (op),
    .busy_o     (busy),
    .done_o     (done)
  );

  pfc_datapath u_dp (
    .clk_i      (clk_i),
    .load_i     (accept),
    .action_i   (in_i.action),
    .freq_mhz_i (in_i.freq_mhz),
    .pll_word_i (in_i.pll_word),
    .op_i       (op),
    .status_o   (status),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= result;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pll_config  = res_q.pll_config;
  assign out_o.freq_out    = res_q.freq_out;
  assign out_o.range_error = res_q.range_error;

endmodule

/* test/tb.sv */
// Self-checking testbench of the PLL frequency codec: stimulus, handshakes and result scoreboard.
`timescale 1ns / 1ps

// Holds the PLL words and frequencies that the codec should answer, in request order,
// and checks every result that the output channel delivers against the oldest one.
class pll_scoreboard;
  pfc_pkg::result_t expected_q[$];
  int unsigned      errors = 0;

  // Builds the PLL word for a frequency and returns the frequency that it achieves.
  // The divider search keeps the last dm with the smallest remainder, so ties go to
  // the larger dm, and it stops once freq*dm passes the top of the dn span.
  static function bit [31:0] encode_pll_word(input bit [11:0] freq,
                                             output bit [11:0] achieved);
    bit [31:0] prod;
    bit [31:0] rem;
    bit [31:0] low_rem;
    bit [31:0] dm;
    bit [31:0] dn;
    bit [31:0] f;
    bit [31:0] range_b;
    low_rem = pfc_pkg::XtalMhz;
    dm      = 1;
    for (int t = 1; t <= pfc_pkg::MaxDm; t++) begin
      prod = freq * t;
      if (prod > pfc_pkg::XLimit) begin
        break;
      end
      rem = prod % pfc_pkg::XtalMhz;
      if (rem <= low_rem) begin
        low_rem = rem;
        dm      = t;
        if (rem == 0) begin
          break;
        end
      end
    end
    dn = (freq * dm) / pfc_pkg::XtalMhz;
    f  = (dn * pfc_pkg::XtalMhz) / dm;
    // Below the base frequency the subtraction wraps around 2^32 before the divide.
    range_b  = ((f - 32'(pfc_pkg::RangeBase)) / pfc_pkg::RangeStep) & 32'hff;
    achieved = f[11:0];
    return {8'h00, 8'(range_b | pfc_pkg::SysDivBit), 8'(dm - 1), 8'(dn - 1)};
  endfunction

  static function pfc_pkg::result_t predict(input bit act, input bit [10:0] freq,
                                            input bit [31:0] word);
    pfc_pkg::result_t res;
    bit [11:0]        achieved;
    bit [31:0]        dn;
    bit [31:0]        dm;
    bit [31:0]        f;
    res = '0;
    if (act == 1'b0) begin
      if (freq < pfc_pkg::MinClock || freq > pfc_pkg::MaxClock) begin
        res.range_error = 1'b1;
      end else begin
        res.pll_config = encode_pll_word({1'b0, freq}, achieved);
        res.freq_out   = achieved;
      end
    end else begin
      dn = {24'd0, word[7:0]} + 1;
      dm = {28'd0, word[11:8]} + 1;
      f  = (dn * pfc_pkg::XtalMhz) / dm;
      // Only a word that re-encodes to itself is canonical.
      if (encode_pll_word(f[11:0], achieved) == word) begin
        res.freq_out = f[11:0];
      end
    end
    return res;
  endfunction

  task report(input string msg);
    if (errors < 100) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  task note_request(input bit act, input bit [10:0] freq, input bit [31:0] word);
    expected_q.push_back(predict(act, freq, word));
  endtask

  task check_result(input pfc_pkg::result_t got);
    pfc_pkg::result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result %h/%0d/%0b with nothing expected",
                       got.pll_config, got.freq_out, got.range_error));
    end else begin
      want = expected_q.pop_front();
      if (got.pll_config !== want.pll_config) begin
        report($sformatf("pll_config %h, expected %h", got.pll_config, want.pll_config));
      end
      if (got.freq_out !== want.freq_out) begin
        report($sformatf("freq_out %0d, expected %0d", got.freq_out, want.freq_out));
      end
      if (got.range_error !== want.range_error) begin
        report($sformatf("range_error %b, expected %b", got.range_error, want.range_error));
      end
    end
  endtask
endclass

module tb;
  import pfc_pkg::*;

  // Item operations on the input channel.
  localparam bit ActEncode = 1'b0;
  localparam bit ActDecode = 1'b1;

  // Margin after the last expected result that lets any late extra result show up.
  localparam int DrainCycles = 40;
  localparam int ItemsPerChunk = 142;

  logic clk_i;
  logic rst_ni;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  pll_frequency_codec DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  pll_scoreboard codec_sb = new;

  // Percentages of cycles in which the sender stays idle and the receiver stalls.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides afresh at every edge whether it takes a result.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Both handshakes are sampled at the rising edge, before any nonblocking update of
  // that edge lands, so every accepted request is predicted in order and every
  // accepted result is checked against the oldest prediction.
  always @(posedge clk_i) begin : channel_monitor
    result_t got;
    if (rst_ni === 1'b1) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        codec_sb.note_request(in_if.action, in_if.freq_mhz, in_if.pll_word);
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.pll_config  = out_if.pll_config;
        got.freq_out    = out_if.freq_out;
        got.range_error = out_if.range_error;
        codec_sb.check_result(got);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid stays high when
  // the next item follows at once, so it is never lowered and raised in one step.
  task automatic send_item(input bit act, input bit [10:0] freq, input bit [31:0] word);
    if ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < idle_pct);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.freq_mhz <= freq;
    in_if.pll_word <= word;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) begin
      @(posedge clk_i);
    end
  endtask

  // Sends the canonical word of a frequency for decoding.
  task automatic send_canonical(input bit [11:0] f);
    bit [11:0] achieved;
    send_item(ActDecode, 11'($urandom), codec_sb.encode_pll_word(f, achieved));
  endtask

  // Random mix: mostly valid encodes and canonical words, the rest encodes of arbitrary
  // frequencies, words with one bit flipped and arbitrary words.
  task automatic random_item();
    int unsigned pick;
    bit [11:0]   f;
    bit [11:0]   achieved;
    bit [31:0]   word;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_item(ActEncode, 11'($urandom_range(MaxClock, MinClock)), $urandom);
    end else if (pick < 50) begin
      send_item(ActEncode, 11'($urandom_range(2047, 0)), $urandom);
    end else if (pick < 82) begin
      if ($urandom_range(1) == 1) begin
        f = 12'($urandom_range(MaxClock, MinClock));
      end else begin
        f = 12'($urandom_range(XLimit, 0));
      end
      word = codec_sb.encode_pll_word(f, achieved);
      if (pick >= 74) begin
        word = word ^ (32'd1 << $urandom_range(31, 0));
      end
      send_item(ActDecode, 11'($urandom), word);
    end else begin
      send_item(ActDecode, 11'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    bit [11:0] achieved;
    bit [31:0] word;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.action   <= ActEncode;
    in_if.freq_mhz <= '0;
    in_if.pll_word <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: range limits, range-code boundaries and the decode corners.
    send_item(ActEncode, 11'(MinClock), 32'h0);
    send_item(ActEncode, 11'(MaxClock), 32'hffffffff);
    send_item(ActEncode, 11'(MinClock - 1), 32'h0);
    send_item(ActEncode, 11'(MaxClock + 1), 32'h0);
    send_item(ActEncode, 11'd0, 32'h0);
    send_item(ActEncode, 11'h7ff, 32'h0);
    send_item(ActEncode, 11'd1100, 32'h0);
    send_item(ActEncode, 11'd1099, 32'h0);
    send_item(ActEncode, 11'd1337, 32'h0);
    send_item(ActEncode, 11'd1700, 32'h0);
    send_canonical(12'(MinClock));
    send_canonical(12'(MaxClock));
    send_canonical(12'd1337);
    // A frequency below the base makes the range code wrap.
    send_canonical(12'd12);
    // A frequency this low gives dn of zero, stored as 0xff in byte 0.
    send_canonical(12'd1);
    send_canonical(12'd0);
    send_canonical(12'(XLimit));
    send_item(ActDecode, 11'h7ff, 32'h0);
    send_item(ActDecode, 11'h0, 32'hffffffff);
    // Upper nibble of byte 1 is ignored by the divider but must still match.
    word = codec_sb.encode_pll_word(12'd1000, achieved);
    send_item(ActDecode, 11'h0, word | 32'h0000f000);
    send_item(ActDecode, 11'h0, word | 32'h01000000);
    send_item(ActDecode, 11'h0, 32'h00200f00);

    // Random part in chunks that cycle through the idling phases.
    for (int chunk = 0; chunk < 8; chunk++) begin
      case (chunk % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 27;
          stall_pct = 27;
        end
      endcase
      repeat (ItemsPerChunk) random_item();
    end
    in_if.valid <= 1'b0;

    // Wait for every expected result, then a little longer for any stray one.
    while (codec_sb.expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (codec_sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Watchdog: a hang or a lost result ends the run here.
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end
endmodule
